/* src/ngnsl_pkg.sv */
// Package for the nested grid nearest seed labeler.
// Holds shared constants, codes and the front-to-back job type; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ngnsl_pkg;
  localparam int SubDefault    = 16;
  localparam int LevelsDefault = 5;
  localparam int SeedsDefault  = 64;
  localparam int IdW     = 21;
  localparam int CoordW  = 32;
  localparam int DistW   = 63;
  localparam int LabelW  = 7;
  localparam int CountW  = 7;
  localparam int ExpW    = 5;
  localparam int IdxW    = 6;

  localparam logic       CMD_LOAD  = 1'b0;
  localparam logic       CMD_LABEL = 1'b1;
  localparam logic [0:0] REG_MIN_EXP    = 1'b0;
  localparam logic [0:0] REG_SEED_COUNT = 1'b1;

  localparam logic [DistW-1:0] DistMax = {DistW{1'b1}};

  // One classified label job handed from the front to the back.
  typedef struct packed {
    logic              covered;
    logic [CoordW-1:0] cx;
    logic [CoordW-1:0] cy;
    logic [CoordW-1:0] cz;
    logic [IdxW:0]     cnt;
  } job_t;
endpackage
`default_nettype wire

/* src/ngnsl_ram.sv */
// Generic single write, single read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module ngnsl_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* src/ngnsl_front.sv */
// Front end: decodes cell ids into cell centres and classifies each word.
// Depends on ngnsl_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ngnsl_front import ngnsl_pkg::*; #(
  parameter int Sub    = SubDefault,
  parameter int Levels = LevelsDefault,
  parameter int Seeds  = SeedsDefault
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [IdW-1:0]            cell_id,
  input  wire logic signed [ExpW-1:0]    min_exp,
  input  wire logic [CountW-1:0]         seed_count,
  output logic                           busy,
  output logic                           job_valid,
  input  wire logic                      job_ready,
  output job_t                           job
);
  localparam int SW   = $clog2(Sub) > 0 ? $clog2(Sub) : 1;
  localparam int Per  = Sub * Sub * Sub;
  localparam int LvW  = $clog2(Levels) > 0 ? $clog2(Levels) : 1;

  // Stage 1: split id by multiples (small divides by constants: iterate digits).
  logic [IdW-1:0] r0, r1, r2, r3, r4, r5;
  logic [LvW-1:0] lvl;
  logic [1:0] bk, bj, bi;
  logic [SW-1:0] sk, sj, si;
  logic in_grid;

  always_comb begin
    r0 = cell_id;
    lvl = '0;
    for (int l = 1; l < 8; l++) begin
      if (l < Levels && r0 >= IdW'(l * 64 * Per)) lvl = LvW'(l);
    end
    r1 = r0 - IdW'(int'(lvl) * 64 * Per);
    bk = r1 >= IdW'(48 * Per) ? 2'd3 : r1 >= IdW'(32 * Per) ? 2'd2 :
         r1 >= IdW'(16 * Per) ? 2'd1 : 2'd0;
    r2 = r1 - IdW'(int'(bk) * 16 * Per);
    bj = r2 >= IdW'(12 * Per) ? 2'd3 : r2 >= IdW'(8 * Per) ? 2'd2 :
         r2 >= IdW'(4 * Per) ? 2'd1 : 2'd0;
    r3 = r2 - IdW'(int'(bj) * 4 * Per);
    bi = r3 >= IdW'(3 * Per) ? 2'd3 : r3 >= IdW'(2 * Per) ? 2'd2 :
         r3 >= IdW'(Per) ? 2'd1 : 2'd0;
    r4 = r3 - IdW'(int'(bi) * Per);
    sk = SW'(r4 / IdW'(Sub * Sub));
    r5 = r4 % IdW'(Sub * Sub);
    sj = SW'(r5 / IdW'(Sub));
    si = SW'(r5 % IdW'(Sub));
    in_grid = {11'd0, cell_id} < 32'(Levels * 64 * Per);
  end

  // Registered decode stage.
  logic s1_valid;
  logic s1_cov;
  logic signed [6:0] s1_sh;
  logic [1:0] s1_b [3];
  logic [SW-1:0] s1_s [3];
  logic [IdxW:0] s1_cnt;
  logic s1_ready;
  logic job_take;

  // The job register loads whenever it is empty or being handed on.
  assign job_take = job_ready || !job_valid;
  assign s1_ready = !s1_valid || job_take;
  assign in_ready = s1_ready;
  assign busy = s1_valid || job_valid;

  // Centre for one axis: ((b-2)*2S + 2s + 1) * 2^sh / 2S, rounded half up.
  function automatic logic [CoordW-1:0] centre(input logic [1:0] b,
                                                input logic [SW-1:0] s,
                                                input logic signed [6:0] sh);
    logic signed [SW+4:0] num;
    logic signed [95:0] v;
    logic signed [95:0] q;
    num = (($signed({3'b0, b}) - 5'sd2) * (SW+5)'(2 * Sub))
          + $signed({3'b0, s, 1'b1});
    v = 96'(num);
    if (sh >= 7'sd0) v = v <<< sh;
    // Divide by 2*Sub (a power of two) with rounding: floor((v + Sub) / 2Sub).
    q = (v + 96'(Sub)) >>> (SW + 1);
    if (q > 96'sh7FFFFFFF) centre = 32'h7FFFFFFF;
    else if (q < -96'sh80000000) centre = 32'h80000000;
    else centre = q[CoordW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      job_valid <= 1'b0;
    end else begin
      if (s1_ready) s1_valid <= in_valid && in_grid;
      if (job_take) job_valid <= s1_valid;
    end
    if (s1_ready && in_valid) begin
      s1_cov <= lvl != '0 && (bk == 2'd1 || bk == 2'd2) && (bj == 2'd1 || bj == 2'd2)
                && (bi == 2'd1 || bi == 2'd2);
      s1_sh <= 7'sd16 + 7'(min_exp) + 7'(lvl);
      s1_b[0] <= bi; s1_b[1] <= bj; s1_b[2] <= bk;
      s1_s[0] <= si; s1_s[1] <= sj; s1_s[2] <= sk;
      s1_cnt <= seed_count == '0 ? (IdxW+1)'(1) :
                seed_count > CountW'(Seeds) ? (IdxW+1)'(Seeds) : seed_count;
    end
    if (job_take) begin
      job.covered <= s1_cov;
      job.cx <= centre(s1_b[0], s1_s[0], s1_sh);
      job.cy <= centre(s1_b[1], s1_s[1], s1_sh);
      job.cz <= centre(s1_b[2], s1_s[2], s1_sh);
      job.cnt <= s1_cnt;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    job_valid && !job_ready |=> job_valid)
    else $error("job dropped while stalled");
  assert property (@(posedge clk) disable iff (rst)
    job_valid |-> job.cnt != '0)
    else $error("empty seed search");
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_grid && in_ready |=> !s1_valid)
    else $error("out of grid id kept");
endmodule
`default_nettype wire

/* src/ngnsl_back.sv */
// Back end: walks the seed memory one seed per cycle and keeps the nearest.
// Depends on ngnsl_pkg and ngnsl_ram.
`timescale 1ns / 1ps
`default_nettype none
module ngnsl_back import ngnsl_pkg::*; #(
  parameter int Seeds = SeedsDefault
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              job_valid,
  output logic                   job_ready,
  input  job_t                   job,
  input  wire logic              load_we,
  input  wire logic [IdxW-1:0]   load_idx,
  input  wire logic [CoordW-1:0] load_x,
  input  wire logic [CoordW-1:0] load_y,
  input  wire logic [CoordW-1:0] load_z,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [LabelW-1:0]      label,
  output logic                   covered,
  output logic [DistW-1:0]       min_dist_sq
);
  localparam int AW = $clog2(Seeds) > 0 ? $clog2(Seeds) : 1;
  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} state_t;
  state_t state;
  job_t cur;
  logic [IdxW:0] rd_n, dn, sq_n, cmp_n;
  logic rd_v, rd_v_next, dv, sq_v;
  logic [CoordW-1:0] rx, ry, rz;
  logic [DistW-1:0] sq [3];
  logic [DistW-1:0] best_d;
  logic [IdxW:0] best;

  ngnsl_ram #(.Width(CoordW), .Depth(Seeds)) u_x (.clk, .we(load_we),
    .waddr(AW'(load_idx)), .wdata(load_x), .raddr(AW'(rd_n)), .rdata(rx));
  ngnsl_ram #(.Width(CoordW), .Depth(Seeds)) u_y (.clk, .we(load_we),
    .waddr(AW'(load_idx)), .wdata(load_y), .raddr(AW'(rd_n)), .rdata(ry));
  ngnsl_ram #(.Width(CoordW), .Depth(Seeds)) u_z (.clk, .we(load_we),
    .waddr(AW'(load_idx)), .wdata(load_z), .raddr(AW'(rd_n)), .rdata(rz));

  function automatic logic [DistW-1:0] sqd(input logic [CoordW-1:0] a,
                                            input logic [CoordW-1:0] b);
    logic signed [CoordW:0] d;
    logic [CoordW-1:0] m;
    logic [63:0] p;
    d = $signed({a[CoordW-1], a}) - $signed({b[CoordW-1], b});
    m = d[CoordW] ? CoordW'(-d) : d[CoordW-1:0];
    p = 64'(m) * 64'(m);
    sqd = p[63] ? DistMax : p[DistW-1:0];
  endfunction

  logic [DistW+1:0] sum;
  logic [DistW-1:0] dsum;
  assign sum = (DistW+2)'(sq[0]) + (DistW+2)'(sq[1]) + (DistW+2)'(sq[2]);
  assign dsum = sum > (DistW+2)'(DistMax) ? DistMax : sum[DistW-1:0];
  assign job_ready = state == S_IDLE;

  // A read is issued for seed rd_n in every cycle that rd_v is high; its data
  // comes out of the RAM in the next cycle (dv) and is squared in the cycle after that.
  assign rd_v_next = (state == S_IDLE && job_valid && !job.covered)
                     || (state == S_RUN && rd_n + 1'b1 < cur.cnt);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      rd_v <= 1'b0;
      dv <= 1'b0;
      sq_v <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;
      rd_v <= rd_v_next;
      dv <= rd_v;
      sq_v <= dv;
      unique case (state)
        S_IDLE: if (job_valid) begin
          cur <= job;
          rd_n <= '0;
          cmp_n <= '0;
          if (job.covered) state <= S_DONE;
          else state <= S_RUN;
        end
        S_RUN: begin
          if (rd_n + 1'b1 < cur.cnt) rd_n <= rd_n + 1'b1;
          if (sq_v) begin
            cmp_n <= cmp_n + 1'b1;
            if (cmp_n == '0 || dsum < best_d) begin
              best_d <= dsum;
              best <= sq_n;
            end
            if (cmp_n + 1'b1 == cur.cnt) state <= S_DONE;
          end
        end
        S_DONE: if (!out_valid || out_ready) begin
          out_valid <= 1'b1;
          covered <= cur.covered;
          label <= cur.covered ? '0 : LabelW'(best + 1'b1);
          min_dist_sq <= cur.covered ? '0 : best_d;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
    if (rd_v) dn <= rd_n;
    if (dv) begin
      sq[0] <= sqd(cur.cx, rx);
      sq[1] <= sqd(cur.cy, ry);
      sq[2] <= sqd(cur.cz, rz);
      sq_n <= dn;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(label))
    else $error("result lost under stall");
  assert property (@(posedge clk) disable iff (rst)
    out_valid && covered |-> label == '0)
    else $error("covered cell labeled");
  assert property (@(posedge clk) disable iff (rst)
    state == S_RUN |-> cmp_n < cur.cnt)
    else $error("search overran seed count");
endmodule
`default_nettype wire

/* src/nested_grid_nearest_seed_labeler_unit.sv */
// Top level of the nested grid nearest seed labeler.
// Depends on ngnsl_pkg, ngnsl_front, ngnsl_back and ngnsl_ram.
//
// Input channel (in_valid/in_ready): each word is a command. A load word
// writes pos_x/y/z into seed slot seed_index and is finished at acceptance;
// it yields no result. A label word carries cell_id; ids beyond the grid
// yield no result, others yield exactly one output word.
// Output channel (out_valid/out_ready): label, covered, min_dist_sq.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0
// is min_exponent, index 1 is seed_count; it is always ready.
// The front end decodes a cell in two register stages and holds one finished
// job; the back end reads one seed per cycle from the seed RAMs and takes a
// new label job only after the previous result has gone to the output
// register, so it works on one label at a time. A covered cell skips the
// seed search. A load waits until no earlier label is still being decoded
// or searched, so every label sees exactly the seeds loaded before it.
// Reset clears all control state; seed slots are undefined until loaded.
// When the receiver stalls, the result is held and the front end fills,
// after which in_ready drops.
`timescale 1ns / 1ps
`default_nettype none
module nested_grid_nearest_seed_labeler_unit import ngnsl_pkg::*; #(
  parameter int Sub    = SubDefault,
  parameter int Levels = LevelsDefault,
  parameter int Seeds  = SeedsDefault
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic                     command,
  input  wire logic [IdxW-1:0]          seed_index,
  input  wire logic signed [CoordW-1:0] pos_x,
  input  wire logic signed [CoordW-1:0] pos_y,
  input  wire logic signed [CoordW-1:0] pos_z,
  input  wire logic [IdW-1:0]           cell_id,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [LabelW-1:0]             label,
  output logic                          covered,
  output logic [DistW-1:0]              min_dist_sq,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [0:0]               cfg_index,
  input  wire logic [CountW-1:0]        cfg_data
);
  logic signed [ExpW-1:0] min_exp;
  logic [CountW-1:0] seed_count;
  logic front_ready, front_busy, job_valid, job_ready;
  job_t job;
  logic is_label;

  assign cfg_ready = 1'b1;
  assign is_label = command == CMD_LABEL;
  // Loads write the RAM only when no earlier label is in the front end or
  // still being searched by the back end.
  assign in_ready = is_label ? front_ready : (!front_busy && job_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      min_exp <= '0;
      seed_count <= CountW'(4);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MIN_EXP:    min_exp <= cfg_data[ExpW-1:0];
        REG_SEED_COUNT: seed_count <= cfg_data;
        default: ;
      endcase
    end
  end

  ngnsl_front #(.Sub(Sub), .Levels(Levels), .Seeds(Seeds)) u_front (
    .clk, .rst, .in_valid(in_valid && is_label), .in_ready(front_ready),
    .cell_id, .min_exp, .seed_count, .busy(front_busy), .job_valid, .job_ready, .job);

  ngnsl_back #(.Seeds(Seeds)) u_back (
    .clk, .rst, .job_valid, .job_ready, .job,
    .load_we(in_valid && in_ready && !is_label && {1'b0, seed_index} < 7'(Seeds)),
    .load_idx(seed_index), .load_x(pos_x), .load_y(pos_y), .load_z(pos_z),
    .out_valid, .out_ready, .label, .covered, .min_dist_sq);

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output dropped");
  assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_index == REG_SEED_COUNT |=> seed_count == $past(cfg_data))
    else $error("seed_count not written");
  assert property (@(posedge clk) rst |=> seed_count == CountW'(4))
    else $error("seed_count reset");
endmodule
`default_nettype wire

/* dv/ngnsl_label_checker.sv */
// Checker for the nested grid nearest seed labeler: watches the input, output and
// configuration channels, predicts each label word and compares. Depends on ngnsl_pkg.
`timescale 1ns / 1ps
module ngnsl_label_checker import ngnsl_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic                     command,
  input  logic [IdxW-1:0]          seed_index,
  input  logic signed [CoordW-1:0] pos_x,
  input  logic signed [CoordW-1:0] pos_y,
  input  logic signed [CoordW-1:0] pos_z,
  input  logic [IdW-1:0]           cell_id,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic [LabelW-1:0]        label,
  input  logic                     covered,
  input  logic [DistW-1:0]         min_dist_sq,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [0:0]               cfg_index,
  input  logic [CountW-1:0]        cfg_data,
  output int                       errors,
  output int                       pending
);
  typedef struct {
    logic [LabelW-1:0] label;
    logic              covered;
    logic [DistW-1:0]  dist_sq;
  } label_word_t;

  localparam int Per = SubDefault * SubDefault * SubDefault;

  logic signed [CoordW-1:0] seed_x [SeedsDefault];
  logic signed [CoordW-1:0] seed_y [SeedsDefault];
  logic signed [CoordW-1:0] seed_z [SeedsDefault];
  logic signed [ExpW-1:0]   min_exp;
  logic [CountW-1:0]        seed_cnt;
  label_word_t              expected_labels[$];

  function automatic longint cell_centre(input int b, input int s, input int sh);
    longint num, v, q;
    num = longint'((b - 2) * 2 * SubDefault + 2 * s + 1);
    v = num * (longint'(1) << sh) + SubDefault;
    q = v / (2 * SubDefault);
    if ((v % (2 * SubDefault)) != 0 && v < 0) q--;
    if (q > longint'(32'h7FFF_FFFF)) q = 32'h7FFF_FFFF;
    if (q < -longint'(33'h0_8000_0000)) q = -longint'(33'h0_8000_0000);
    return q;
  endfunction

  function automatic longint unsigned axis_sq(input longint a, input longint b);
    longint d;
    longint unsigned m, q;
    d = a - b;
    m = (d < 0) ? longint'(-d) : d;
    if (m > 64'hFFFF_FFFF) return {1'b0, DistMax};
    q = m * m;
    return (q > {1'b0, DistMax}) ? {1'b0, DistMax} : q;
  endfunction

  function automatic longint unsigned sat_sum(input longint unsigned a,
                                              input longint unsigned b);
    longint unsigned s;
    s = a + b;
    return (s > {1'b0, DistMax}) ? {1'b0, DistMax} : s;
  endfunction

  // Returns 0 for ids beyond the grid, which give no word.
  function automatic bit nearest_seed_of_cell(input logic [IdW-1:0] id,
                                              output label_word_t w);
    int unsigned lvl, bk, bj, bi, sk, sj, si, rem;
    int sh, cnt, best;
    longint cx, cy, cz;
    longint unsigned d, best_d;
    if (id >= LevelsDefault * 64 * Per) return 0;
    lvl = id / (Per * 64);
    rem = id % (Per * 64);
    bk = rem / (Per * 16); rem = rem % (Per * 16);
    bj = rem / (Per * 4);  rem = rem % (Per * 4);
    bi = rem / Per;        rem = rem % Per;
    sk = rem / (SubDefault * SubDefault);
    rem = rem % (SubDefault * SubDefault);
    sj = rem / SubDefault;
    si = rem % SubDefault;
    if (lvl != 0 && bk inside {[1:2]} && bj inside {[1:2]} && bi inside {[1:2]}) begin
      w.label = '0;
      w.covered = 1'b1;
      w.dist_sq = '0;
      return 1;
    end
    sh = 16 + int'(min_exp) + int'(lvl);
    cx = cell_centre(bi, si, sh);
    cy = cell_centre(bj, sj, sh);
    cz = cell_centre(bk, sk, sh);
    cnt = (seed_cnt == 0) ? 1 : (seed_cnt > SeedsDefault ? SeedsDefault : int'(seed_cnt));
    best = 0;
    best_d = 0;
    for (int n = 0; n < cnt; n++) begin
      d = axis_sq(cx, longint'(seed_x[n]));
      d = sat_sum(d, axis_sq(cy, longint'(seed_y[n])));
      d = sat_sum(d, axis_sq(cz, longint'(seed_z[n])));
      if (n == 0 || d < best_d) begin
        best_d = d;
        best = n;
      end
    end
    w.label = LabelW'(best + 1);
    w.covered = 1'b0;
    w.dist_sq = best_d[DistW-1:0];
    return 1;
  endfunction

  assign pending = expected_labels.size();

  always @(posedge clk) begin
    label_word_t w, got;
    if (rst) begin
      min_exp <= '0;
      seed_cnt <= CountW'(4);
      errors <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_MIN_EXP) min_exp <= cfg_data[ExpW-1:0];
        else seed_cnt <= cfg_data;
      end
      if (in_valid && in_ready) begin
        if (command == CMD_LOAD) begin
          seed_x[seed_index] <= pos_x;
          seed_y[seed_index] <= pos_y;
          seed_z[seed_index] <= pos_z;
        end else if (nearest_seed_of_cell(cell_id, w)) begin
          expected_labels.insert(expected_labels.size(), w);
        end
      end
      if (out_valid && out_ready) begin
        got.label = label;
        got.covered = covered;
        got.dist_sq = min_dist_sq;
        if (expected_labels.size() == 0) begin
          $display("%0t: unexpected word label=%0d covered=%0d dist=%0h",
                   $time, label, covered, min_dist_sq);
          errors <= errors + 1;
        end else begin
          w = expected_labels.pop_front();
          if (w.label !== got.label || w.covered !== got.covered ||
              w.dist_sq !== got.dist_sq) begin
            $display("%0t: mismatch expected label=%0d covered=%0d dist=%0h",
                     $time, w.label, w.covered, w.dist_sq);
            $display("%0t:          actual   label=%0d covered=%0d dist=%0h",
                     $time, got.label, got.covered, got.dist_sq);
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule

/* dv/tb_nested_grid_nearest_seed_labeler_unit.sv */
// Testbench top for the nested grid nearest seed labeler: drives load and label
// words and register writes, and gives the verdict. Depends on ngnsl_pkg and ngnsl_label_checker.
`timescale 1ns / 1ps
module tb_nested_grid_nearest_seed_labeler_unit;
  import ngnsl_pkg::*;

  localparam int  CycleLimit = 3_000_000;
  // A label word comes only after a search over up to 64 seeds, and ids beyond
  // the grid give no word at all, so we settle this long.
  localparam int  SettleCycles = 100;
  localparam int  GridCells = LevelsDefault * 64 * SubDefault * SubDefault * SubDefault;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     in_valid, in_ready;
  logic                     command;
  logic [IdxW-1:0]          seed_index;
  logic signed [CoordW-1:0] pos_x, pos_y, pos_z;
  logic [IdW-1:0]           cell_id;
  logic                     out_valid, out_ready;
  logic [LabelW-1:0]        label;
  logic                     covered;
  logic [DistW-1:0]         min_dist_sq;
  logic                     cfg_valid, cfg_ready;
  logic [0:0]               cfg_index;
  logic [CountW-1:0]        cfg_data;
  int                       errors, pending;
  int                       cycles = 0;
  bit                       quiet = 0;      // no idling on either side
  bit                       hold_request = 0;

  always #4 clk = ~clk;

  nested_grid_nearest_seed_labeler_unit u_dut (.*);

  ngnsl_label_checker u_checker (.*);

  // Run limit, counted in cycles.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb_nested_grid_nearest_seed_labeler_unit: errors");
      $finish;
    end
  end

  // Receiver: short random stalls, plus one long hold-off on request so that the
  // block backs up and drops in_ready while the sender keeps offering words.
  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 0;
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Offers one word and returns at the edge where it was taken. An optional
  // gap follows, so idle cycles land on every phase of the search.
  task automatic send_word(input logic cmd, input logic [IdxW-1:0] idx,
                           input logic [CoordW-1:0] x, input logic [CoordW-1:0] y,
                           input logic [CoordW-1:0] z, input logic [IdW-1:0] id);
    in_valid <= 1'b1;
    command <= cmd;
    seed_index <= idx;
    pos_x <= x;
    pos_y <= y;
    pos_z <= z;
    cell_id <= id;
    do @(posedge clk); while (!in_ready);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic load_seed(input int idx, input logic [CoordW-1:0] x,
                           input logic [CoordW-1:0] y, input logic [CoordW-1:0] z);
    send_word(CMD_LOAD, IdxW'(idx), x, y, z, IdW'($urandom));
  endtask

  task automatic label_cell(input logic [IdW-1:0] id);
    send_word(CMD_LABEL, IdxW'($urandom), $urandom, $urandom, $urandom, id);
  endtask

  // Waits until every expected word is in, then idles for SettleCycles more
  // before anything touches the registers.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [CountW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [IdW-1:0] cell_at(input int lvl, input int bk, input int bj,
                                             input int bi, input int sk, input int sj,
                                             input int si);
    return IdW'((((((lvl * 4 + bk) * 4 + bj) * 4 + bi) * SubDefault + sk) * SubDefault + sj)
                * SubDefault + si);
  endfunction

  // Mostly well-formed cells, some forced into the covered block, a few raw ids
  // that can land beyond the grid.
  function automatic logic [IdW-1:0] rand_cell();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return IdW'($urandom);
    if (pick == 1) return IdW'($urandom_range(GridCells, (1 << IdW) - 1));
    if (pick <= 3)
      return cell_at($urandom_range(1, LevelsDefault - 1), $urandom_range(1, 2),
                     $urandom_range(1, 2), $urandom_range(1, 2),
                     $urandom_range(0, SubDefault - 1), $urandom_range(0, SubDefault - 1),
                     $urandom_range(0, SubDefault - 1));
    return cell_at($urandom_range(0, LevelsDefault - 1), $urandom_range(0, 3),
                   $urandom_range(0, 3), $urandom_range(0, 3),
                   $urandom_range(0, SubDefault - 1), $urandom_range(0, SubDefault - 1),
                   $urandom_range(0, SubDefault - 1));
  endfunction

  // Coordinates spread over all magnitudes so that seeds fall near cells at
  // every exponent, with the signed extremes mixed in.
  function automatic logic [CoordW-1:0] rand_coord();
    logic signed [CoordW-1:0] v;
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return '0;
      3, 4: return $urandom;
      default: begin
        v = $urandom;
        return v >>> $urandom_range(0, 31);
      end
    endcase
  endfunction

  initial begin
    int min_exp_set[7] = '{-8, 8, 0, -16, 15, 3, -5};
    int count_set[7]   = '{1, 64, 0, 127, 17, 64, 7};
    logic [CoordW-1:0] same;
    rst <= 1'b1;
    in_valid <= 1'b0;
    command <= CMD_LOAD;
    seed_index <= '0;
    pos_x <= '0;
    pos_y <= '0;
    pos_z <= '0;
    cell_id <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_MIN_EXP;
    cfg_data <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Every slot gets the same point first, so all seeds tie and the lowest
    // index must win; no slot is ever read before it was written.
    same = 32'h0001_8000;
    for (int n = 0; n < SeedsDefault; n++) load_seed(n, same, same, same);
    label_cell('0);
    label_cell(cell_at(0, 3, 3, 3, SubDefault - 1, SubDefault - 1, SubDefault - 1));

    // Directed: coordinate extremes, grid corners, covered and out-of-grid ids.
    load_seed(2, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    load_seed(3, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    load_seed(1, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_8000);
    label_cell(IdW'(GridCells - 1));
    label_cell(cell_at(0, 0, 0, 0, 0, 0, 0));
    label_cell(cell_at(LevelsDefault - 1, 0, 0, 0, 0, 0, 0));
    label_cell(cell_at(LevelsDefault - 1, 3, 3, 3, SubDefault - 1, SubDefault - 1,
                       SubDefault - 1));
    label_cell(cell_at(1, 1, 1, 1, 0, 0, 0));
    label_cell(cell_at(LevelsDefault - 1, 2, 2, 2, SubDefault - 1, SubDefault - 1,
                       SubDefault - 1));
    label_cell(cell_at(1, 1, 1, 3, 5, 5, 5));
    label_cell(cell_at(0, 1, 1, 1, 7, 8, 9));
    label_cell(IdW'(GridCells));
    label_cell('1);
    load_seed(0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    label_cell(cell_at(2, 0, 3, 0, 0, SubDefault - 1, 0));

    // Phases, each under its own register setting.
    for (int p = 0; p < 7; p++) begin
      wait_drained();
      write_reg(REG_MIN_EXP, {CountW'($urandom) & ~CountW'((1 << ExpW) - 1)}
                             | CountW'(ExpW'(min_exp_set[p])));
      write_reg(REG_SEED_COUNT, CountW'(count_set[p]));
      if (p == 6) quiet = 1;
      for (int k = 0; k < 200; k++) begin
        if (p == 1 && k == 20) hold_request = 1;
        // The sender once waits for every outstanding word mid-phase.
        if (p == 2 && k == 100) wait_drained();
        if ($urandom_range(0, 6) == 0) load_seed($urandom_range(0, SeedsDefault - 1),
                                                 rand_coord(), rand_coord(), rand_coord());
        else label_cell(rand_cell());
      end
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SettleCycles) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tb_nested_grid_nearest_seed_labeler_unit: clean");
    end else begin
      $display("tb_nested_grid_nearest_seed_labeler_unit: errors");
    end
    $finish;
  end
endmodule
